[sv/cha_pkg.sv]
`timescale 1ns / 1ps

package cha_pkg;

    typedef logic [31:0]     word_t;
    typedef word_t [3:0]     quad_t;
    typedef word_t [15:0]    block_t;

    // Fixed words 0..3: "expand 32-byte k"
    localparam word_t SIGMA_0 = 32'h6170_7865;
    localparam word_t SIGMA_1 = 32'h3320_646E;
    localparam word_t SIGMA_2 = 32'h7962_2D32;
    localparam word_t SIGMA_3 = 32'h6B20_6574;

    localparam int unsigned ROT_A = 16;
    localparam int unsigned ROT_B = 12;
    localparam int unsigned ROT_C = 8;
    localparam int unsigned ROT_D = 7;

    localparam int unsigned DBL_ROUNDS_W = 4;
    localparam int unsigned RND_CNT_W    = DBL_ROUNDS_W + 1;
    localparam logic [DBL_ROUNDS_W-1:0] DBL_ROUNDS_RESET = 4'd10;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_PAIR_0    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_PAIR_1    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_PAIR_2    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_PAIR_3    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_NONCE_VALUE   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_COUNTER_START = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_DOUBLE_ROUNDS = 3'd6;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic round;
        logic finish;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic rnd_zero;
        logic out_full;
        logic out_taken;
    } dp_status_t;

    function automatic word_t rotl(word_t v, int unsigned n);
        return (v << n) | (v >> (32 - n));
    endfunction

    // One quarter round; q[0..3] hold a, b, c, d
    function automatic quad_t quarter(quad_t q);
        quad_t r;
        r = q;
        r[0] = r[0] + r[1]; r[3] = rotl(r[3] ^ r[0], ROT_A);
        r[2] = r[2] + r[3]; r[1] = rotl(r[1] ^ r[2], ROT_B);
        r[0] = r[0] + r[1]; r[3] = rotl(r[3] ^ r[0], ROT_C);
        r[2] = r[2] + r[3]; r[1] = rotl(r[1] ^ r[2], ROT_D);
        return r;
    endfunction

    // Four parallel quarter rounds over columns or diagonals
    function automatic block_t half_round(block_t x, logic diag);
        block_t y;
        y = x;
        if (!diag)
        begin
            {y[12], y[8],  y[4], y[0]} = quarter({x[12], x[8],  x[4], x[0]});
            {y[13], y[9],  y[5], y[1]} = quarter({x[13], x[9],  x[5], x[1]});
            {y[14], y[10], y[6], y[2]} = quarter({x[14], x[10], x[6], x[2]});
            {y[15], y[11], y[7], y[3]} = quarter({x[15], x[11], x[7], x[3]});
        end
        else
        begin
            {y[15], y[10], y[5], y[0]} = quarter({x[15], x[10], x[5], x[0]});
            {y[12], y[11], y[6], y[1]} = quarter({x[12], x[11], x[6], x[1]});
            {y[13], y[8],  y[7], y[2]} = quarter({x[13], x[8],  x[7], x[2]});
            {y[14], y[9],  y[4], y[3]} = quarter({x[14], x[9],  x[4], x[3]});
        end
        return y;
    endfunction

endpackage

[sv/cha_req_if.sv]
`timescale 1ns / 1ps

interface cha_req_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

[sv/cha_rsp_if.sv]
`timescale 1ns / 1ps

interface cha_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] keystream_pair_0;
    logic [63:0] keystream_pair_1;
    logic [63:0] keystream_pair_2;
    logic [63:0] keystream_pair_3;
    logic [63:0] keystream_pair_4;
    logic [63:0] keystream_pair_5;
    logic [63:0] keystream_pair_6;
    logic [63:0] keystream_pair_7;
    logic [63:0] block_number;

    modport source (
        output valid, input ready,
        output keystream_pair_0, output keystream_pair_1,
        output keystream_pair_2, output keystream_pair_3,
        output keystream_pair_4, output keystream_pair_5,
        output keystream_pair_6, output keystream_pair_7,
        output block_number
    );
    modport sink (
        input valid, output ready,
        input keystream_pair_0, input keystream_pair_1,
        input keystream_pair_2, input keystream_pair_3,
        input keystream_pair_4, input keystream_pair_5,
        input keystream_pair_6, input keystream_pair_7,
        input block_number
    );
endinterface

[sv/cha_ctrl.sv]
`timescale 1ns / 1ps

module cha_ctrl
    import cha_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_ROUND  = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Sequence: take a request, run the half rounds, hand off the result
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                if (status.rnd_zero)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.round = 1'b1;
                end
            end
            ST_FINISH:
            begin
                // Wait for the output register to free up
                if (!status.out_full || status.out_taken)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[sv/cha_datapath.sv]
`timescale 1ns / 1ps

module cha_datapath
    import cha_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [63:0]            cfg_data,
    input  logic                   req_restart,
    input  logic                   rsp_ready,
    input  ctrl_cmd_t              cmd,
    output dp_status_t             status,
    output logic                   rsp_valid,
    output block_t                 keystream,
    output logic [63:0]            block_number
);

    logic [63:0]             key_pair_reg [4];
    logic [63:0]             nonce_reg;
    logic [63:0]             ctr_start_reg;
    logic [DBL_ROUNDS_W-1:0] dbl_rounds_reg;

    logic [63:0]          ctr_reg, ctr_next;
    logic [RND_CNT_W-1:0] rnd_cnt_reg, rnd_cnt_next;
    block_t               x_reg, x_next;
    logic                 out_valid_reg, out_valid_next;
    block_t               ks_reg;
    logic [63:0]          blk_num_reg;

    logic [63:0] ctr_sel;
    block_t      init_load;
    block_t      init_cur;
    block_t      ks_sum;

    // Write configuration registers; unknown indexes drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_pair_reg[0] <= '0;
            key_pair_reg[1] <= '0;
            key_pair_reg[2] <= '0;
            key_pair_reg[3] <= '0;
            nonce_reg       <= '0;
            ctr_start_reg   <= '0;
            dbl_rounds_reg  <= DBL_ROUNDS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_KEY_PAIR_0:    key_pair_reg[0] <= cfg_data;
                CFG_KEY_PAIR_1:    key_pair_reg[1] <= cfg_data;
                CFG_KEY_PAIR_2:    key_pair_reg[2] <= cfg_data;
                CFG_KEY_PAIR_3:    key_pair_reg[3] <= cfg_data;
                CFG_NONCE_VALUE:   nonce_reg       <= cfg_data;
                CFG_COUNTER_START: ctr_start_reg   <= cfg_data;
                CFG_DOUBLE_ROUNDS: dbl_rounds_reg  <= cfg_data[DBL_ROUNDS_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Pick the counter for a new request
    assign ctr_sel = req_restart ? ctr_start_reg : ctr_reg;

    // Build the input block for a given counter
    always_comb
    begin
        init_load = {nonce_reg[63:32], nonce_reg[31:0],
                     ctr_sel[63:32], ctr_sel[31:0],
                     key_pair_reg[3][63:32], key_pair_reg[3][31:0],
                     key_pair_reg[2][63:32], key_pair_reg[2][31:0],
                     key_pair_reg[1][63:32], key_pair_reg[1][31:0],
                     key_pair_reg[0][63:32], key_pair_reg[0][31:0],
                     SIGMA_3, SIGMA_2, SIGMA_1, SIGMA_0};
        init_cur  = init_load;
        init_cur[12] = ctr_reg[31:0];
        init_cur[13] = ctr_reg[63:32];
    end

    // Add the input words back
    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            ks_sum[i] = x_reg[i] + init_cur[i];
        end
    end

    // Next-state logic for the working block and counters
    always_comb
    begin
        ctr_next       = ctr_reg;
        rnd_cnt_next   = rnd_cnt_reg;
        x_next         = x_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.load)
        begin
            ctr_next     = ctr_sel;
            x_next       = init_load;
            rnd_cnt_next = {dbl_rounds_reg, 1'b0};
        end
        if (cmd.round)
        begin
            // Even count runs the columns, odd the diagonals
            x_next       = half_round(x_reg, rnd_cnt_reg[0]);
            rnd_cnt_next = rnd_cnt_reg - RND_CNT_W'(1);
        end
        if (cmd.finish)
        begin
            ctr_next       = ctr_reg + 64'd1;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctr_reg       <= '0;
            rnd_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ctr_reg       <= ctr_next;
            rnd_cnt_reg   <= rnd_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the working block and the result
    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        if (cmd.finish)
        begin
            ks_reg      <= ks_sum;
            blk_num_reg <= ctr_reg;
        end
    end

    assign status.rnd_zero  = (rnd_cnt_reg == '0);
    assign status.out_full  = out_valid_reg;
    assign status.out_taken = out_valid_reg && rsp_ready;

    assign rsp_valid    = out_valid_reg;
    assign keystream    = ks_reg;
    assign block_number = blk_num_reg;

endmodule

[sv/chacha_keystream_block.sv]
`timescale 1ns / 1ps
// A request loads the input block, runs the half rounds (four parallel quarter rounds
// each, one half round per cycle in the datapath), then adds the input words back
// and registers the result once the output register is free.
// A new request is taken while the previous result still waits in the output register.
// Reset (async, active low): keys, nonce, counter start and block counter clear,
// double_rounds returns to 10, no result pending.

module chacha_keystream_block
    import cha_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [63:0]            cfg_data,
    cha_req_if.sink                req,
    cha_rsp_if.source              rsp
);

    ctrl_cmd_t   cmd;
    dp_status_t  status;
    block_t      keystream;
    logic        req_ready;

    cha_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    cha_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .req_restart  (req.restart),
        .rsp_ready    (rsp.ready),
        .cmd          (cmd),
        .status       (status),
        .rsp_valid    (rsp.valid),
        .keystream    (keystream),
        .block_number (rsp.block_number)
    );

    assign req.ready = req_ready;

    // Pack output words in pairs, even word in the low half
    assign rsp.keystream_pair_0 = {keystream[1],  keystream[0]};
    assign rsp.keystream_pair_1 = {keystream[3],  keystream[2]};
    assign rsp.keystream_pair_2 = {keystream[5],  keystream[4]};
    assign rsp.keystream_pair_3 = {keystream[7],  keystream[6]};
    assign rsp.keystream_pair_4 = {keystream[9],  keystream[8]};
    assign rsp.keystream_pair_5 = {keystream[11], keystream[10]};
    assign rsp.keystream_pair_6 = {keystream[13], keystream[12]};
    assign rsp.keystream_pair_7 = {keystream[15], keystream[14]};

endmodule

[sv/cha_checker.sv]
`timescale 1ns / 1ps

module cha_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [63:0] block_number
);

    // A waiting result holds until taken
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(block_number))
        else $error("result dropped or changed while stalled");

    // The block is busy right after taking a request
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while block busy");

    // A result never appears the cycle after a request
    a_no_instant_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !$rose(rsp_valid))
        else $error("result appeared before any round ran");

    // A fresh result leaves the block free for the next request
    a_free_on_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> req_ready)
        else $error("block not free when result delivered");

endmodule

bind chacha_keystream_block cha_checker u_cha_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .block_number (rsp.block_number)
);

[tb/tb_chacha_keystream_block.sv]
`timescale 1ns / 1ps

module tb_chacha_keystream_block;
    import cha_pkg::*;

    typedef logic [31:0] u32_t;

    // One keystream block as the response carries it; number sits in the low 64 bits
    typedef struct packed {
        logic [7:0][63:0] pair;
        logic [63:0]      number;
    } keystream_t;

    typedef enum logic [1:0] {KNOWN_NONE, KNOWN_NUMBER, KNOWN_ALL} known_t;
    typedef enum logic {ROW_WRITE, ROW_BLOCK} row_kind_t;

    typedef struct {
        row_kind_t              kind;
        logic [CFG_INDEX_W-1:0] index;
        logic [63:0]            data;
        logic                   restart;
        known_t                 known;
        keystream_t             block;
    } plan_row_t;

    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 3'd7;
    localparam int TOTAL_REQUESTS = 1600;
    localparam int HOLD_CYCLES    = 300;

    // Doubled input words, as seen with no rounds at all
    localparam logic [63:0] SIG_LO2 = 64'h6640C8DC_C2E0F0CA;
    localparam logic [63:0] SIG_HI2 = 64'hD640CAE8_F2C45A64;
    localparam logic [63:0] ONES2   = 64'hFFFFFFFE_FFFFFFFE;
    localparam logic [63:0] ALL1    = 64'hFFFF_FFFF_FFFF_FFFF;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [63:0]            cfg_data = '0;

    cha_req_if req_bus ();
    cha_rsp_if rsp_bus ();

    chacha_keystream_block dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_bus),
        .rsp       (rsp_bus)
    );

    // Mirror of the block's registers and counter
    logic [63:0] key_cfg [4];
    logic [63:0] nonce_cfg;
    logic [63:0] ctr_start_cfg;
    logic [63:0] block_ctr;
    logic [3:0]  rounds_cfg;

    keystream_t  pending_blocks [$];
    int          mismatch_count = 0;
    int          requests_sent = 0;
    bit          gaps_on = 1'b1;
    int          hold_len = 0;

    // Expectation override that travels with the request
    known_t      known_kind = KNOWN_NONE;
    keystream_t  known_block = '0;

    always
    begin
        #2;
        clk = 1'b1;
        #2;
        clk = 1'b0;
    end

    function automatic u32_t rol(input u32_t v, input int n);
        logic [63:0] t;
        t = {v, v} << n;
        return t[63:32];
    endfunction

    function automatic logic [127:0] mix(input u32_t a, input u32_t b, input u32_t c,
                                         input u32_t d);
        a = a + b; d = rol(d ^ a, 16);
        c = c + d; b = rol(b ^ c, 12);
        a = a + b; d = rol(d ^ a, 8);
        c = c + d; b = rol(b ^ c, 7);
        return {a, b, c, d};
    endfunction

    // Compute one keystream block from the mirrored registers and a counter
    function automatic keystream_t chacha_block_words(input logic [63:0] ctr);
        u32_t       start [16];
        u32_t       st [16];
        keystream_t blk;
        start[0] = 32'h6170_7865;
        start[1] = 32'h3320_646E;
        start[2] = 32'h7962_2D32;
        start[3] = 32'h6B20_6574;
        for (int i = 0; i < 4; i++)
        begin
            start[4 + 2 * i] = key_cfg[i][31:0];
            start[5 + 2 * i] = key_cfg[i][63:32];
        end
        start[12] = ctr[31:0];
        start[13] = ctr[63:32];
        start[14] = nonce_cfg[31:0];
        start[15] = nonce_cfg[63:32];
        st = start;
        for (int r = 0; r < rounds_cfg; r++)
        begin
            {st[0], st[4], st[8],  st[12]} = mix(st[0], st[4], st[8],  st[12]);
            {st[1], st[5], st[9],  st[13]} = mix(st[1], st[5], st[9],  st[13]);
            {st[2], st[6], st[10], st[14]} = mix(st[2], st[6], st[10], st[14]);
            {st[3], st[7], st[11], st[15]} = mix(st[3], st[7], st[11], st[15]);
            {st[0], st[5], st[10], st[15]} = mix(st[0], st[5], st[10], st[15]);
            {st[1], st[6], st[11], st[12]} = mix(st[1], st[6], st[11], st[12]);
            {st[2], st[7], st[8],  st[13]} = mix(st[2], st[7], st[8],  st[13]);
            {st[3], st[4], st[9],  st[14]} = mix(st[3], st[4], st[9],  st[14]);
        end
        for (int i = 0; i < 8; i++)
            blk.pair[i] = {st[2 * i + 1] + start[2 * i + 1], st[2 * i] + start[2 * i]};
        blk.number = ctr;
        return blk;
    endfunction

    function automatic plan_row_t cfg_row(input logic [CFG_INDEX_W-1:0] idx,
                                          input logic [63:0] data);
        plan_row_t row;
        row = '{ROW_WRITE, idx, data, 1'b0, KNOWN_NONE, '0};
        return row;
    endfunction

    function automatic plan_row_t block_row(input logic restart, input known_t known,
                                            input keystream_t blk);
        plan_row_t row;
        row = '{ROW_BLOCK, '0, '0, restart, known, blk};
        return row;
    endfunction

    // Write one register and track it in the mirror
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            CFG_KEY_PAIR_0:    key_cfg[0] = data;
            CFG_KEY_PAIR_1:    key_cfg[1] = data;
            CFG_KEY_PAIR_2:    key_cfg[2] = data;
            CFG_KEY_PAIR_3:    key_cfg[3] = data;
            CFG_NONCE_VALUE:   nonce_cfg = data;
            CFG_COUNTER_START: ctr_start_cfg = data;
            CFG_DOUBLE_ROUNDS: rounds_cfg = data[3:0];
            default: ; // indexes past the last register are dropped
        endcase
    endtask

    // Offer one request, after a random gap while gaps are on, and hold it until taken
    task automatic send_block(input logic restart, input known_t known,
                              input keystream_t blk);
        int gap;
        gap = gaps_on ? $urandom_range(0, 15) : 0;
        // close any register write burst
        cfg_we <= 1'b0;
        if (gap != 0)
        begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_bus.valid   <= 1'b1;
        req_bus.restart <= restart;
        known_kind      <= known;
        known_block     <= blk;
        do @(posedge clk); while (!req_bus.ready);
        requests_sent++;
    endtask

    // Stop requesting and wait for every outstanding block
    task automatic drain();
        req_bus.valid <= 1'b0;
        do @(posedge clk); while (pending_blocks.size() != 0);
    endtask

    // Predict on each accepted request, check each accepted response
    always @(posedge clk)
    begin : watch
        keystream_t want;
        keystream_t seen;
        if (rst_n)
        begin
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                seen.pair = {rsp_bus.keystream_pair_7, rsp_bus.keystream_pair_6,
                             rsp_bus.keystream_pair_5, rsp_bus.keystream_pair_4,
                             rsp_bus.keystream_pair_3, rsp_bus.keystream_pair_2,
                             rsp_bus.keystream_pair_1, rsp_bus.keystream_pair_0};
                seen.number = rsp_bus.block_number;
                if (pending_blocks.size() == 0)
                begin
                    $display("%0t: response expected none, got block_number %h",
                             $time, seen.number);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_blocks.pop_front();
                    for (int k = 0; k < 8; k++)
                    begin
                        if (seen.pair[k] !== want.pair[k])
                        begin
                            $display("%0t: keystream_pair_%0d expected %h, got %h",
                                     $time, k, want.pair[k], seen.pair[k]);
                            mismatch_count++;
                        end
                    end
                    if (seen.number !== want.number)
                    begin
                        $display("%0t: block_number expected %h, got %h",
                                 $time, want.number, seen.number);
                        mismatch_count++;
                    end
                end
            end
            if (req_bus.valid && req_bus.ready)
            begin
                if (req_bus.restart)
                    block_ctr = ctr_start_cfg;
                want = chacha_block_words(block_ctr);
                block_ctr = block_ctr + 64'd1;
                if (known_kind == KNOWN_ALL)
                    want = known_block;
                else if (known_kind == KNOWN_NUMBER)
                    want.number = known_block.number;
                pending_blocks.push_back(want);
            end
        end
    end

    // Response side: random stalls while gaps are on, plus one long hold-off on request
    initial
    begin
        int stall;
        rsp_bus.ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            stall = gaps_on ? $urandom_range(0, 15) : 0;
            if (hold_len != 0)
            begin
                stall = hold_len;
                hold_len = 0;
            end
            if (stall != 0)
            begin
                rsp_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_bus.ready <= 1'b1;
            do @(posedge clk); while (!rsp_bus.valid);
        end
    end

    initial
    begin
        #3_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        plan_row_t   plan [$];
        logic [63:0] value;
        int          phase;
        int          count;

        req_bus.valid   <= 1'b0;
        req_bus.restart <= 1'b0;
        for (int i = 0; i < 4; i++)
            key_cfg[i] = '0;
        nonce_cfg     = '0;
        ctr_start_cfg = '0;
        block_ctr     = '0;
        rounds_cfg    = 4'd10;

        // Counter after reset, restart, and the all-zero block
        plan.push_back(block_row(1'b0, KNOWN_NUMBER, keystream_t'(64'd0)));
        plan.push_back(block_row(1'b0, KNOWN_NUMBER, keystream_t'(64'd1)));
        plan.push_back(block_row(1'b1, KNOWN_NUMBER, keystream_t'(64'd0)));
        // No rounds: every output word is its input word doubled
        plan.push_back(cfg_row(CFG_DOUBLE_ROUNDS, 64'd0));
        plan.push_back(block_row(1'b1, KNOWN_ALL,
            keystream_t'({64'h0, 64'h0, {4{64'h0}}, SIG_HI2, SIG_LO2, 64'h0})));
        plan.push_back(cfg_row(CFG_KEY_PAIR_0, ALL1));
        plan.push_back(cfg_row(CFG_KEY_PAIR_1, ALL1));
        plan.push_back(cfg_row(CFG_KEY_PAIR_2, ALL1));
        plan.push_back(cfg_row(CFG_KEY_PAIR_3, ALL1));
        plan.push_back(cfg_row(CFG_NONCE_VALUE, ALL1));
        plan.push_back(cfg_row(CFG_COUNTER_START, ALL1));
        // A new counter start leaves the running counter alone
        plan.push_back(block_row(1'b0, KNOWN_ALL,
            keystream_t'({ONES2, 64'h2, {4{ONES2}}, SIG_HI2, SIG_LO2, 64'h1})));
        plan.push_back(block_row(1'b1, KNOWN_ALL,
            keystream_t'({ONES2, ONES2, {4{ONES2}}, SIG_HI2, SIG_LO2, ALL1})));
        // Counter wraps to zero
        plan.push_back(block_row(1'b0, KNOWN_ALL,
            keystream_t'({ONES2, 64'h0, {4{ONES2}}, SIG_HI2, SIG_LO2, 64'h0})));
        plan.push_back(cfg_row(CFG_UNUSED, 64'd5));
        plan.push_back(block_row(1'b0, KNOWN_ALL,
            keystream_t'({ONES2, 64'h2, {4{ONES2}}, SIG_HI2, SIG_LO2, 64'h1})));
        // Round counts outside the usual range, with high data bits set
        plan.push_back(cfg_row(CFG_DOUBLE_ROUNDS, ALL1));
        plan.push_back(block_row(1'b0, KNOWN_NUMBER, keystream_t'(64'd2)));
        plan.push_back(cfg_row(CFG_DOUBLE_ROUNDS, 64'd1));
        plan.push_back(block_row(1'b1, KNOWN_NUMBER, keystream_t'(ALL1)));
        plan.push_back(cfg_row(CFG_DOUBLE_ROUNDS, 64'd10));
        plan.push_back(cfg_row(CFG_KEY_PAIR_0, 64'hAAAA_AAAA_AAAA_AAAA));
        plan.push_back(cfg_row(CFG_KEY_PAIR_1, 64'h5555_5555_5555_5555));
        plan.push_back(cfg_row(CFG_COUNTER_START, 64'h0000_0000_FFFF_FFFF));
        // Carry from the low counter word into the high one
        plan.push_back(block_row(1'b1, KNOWN_NUMBER, keystream_t'(64'h0000_0000_FFFF_FFFF)));
        plan.push_back(block_row(1'b0, KNOWN_NUMBER, keystream_t'(64'h0000_0001_0000_0000)));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the directed plan
        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_WRITE)
            begin
                if (i > 0 && plan[i - 1].kind == ROW_BLOCK)
                    drain();
                write_reg(plan[i].index, plan[i].data);
            end
            else
                send_block(plan[i].restart, plan[i].known, plan[i].block);
        end

        // Random phases: reprogram while idle, then stream requests
        for (phase = 0; requests_sent < TOTAL_REQUESTS; phase++)
        begin
            drain();
            for (int idx = 0; idx < 8; idx++)
            begin
                if ($urandom_range(0, 1) == 0)
                    continue;
                value = {$urandom, $urandom};
                case (CFG_INDEX_W'(idx))
                    CFG_COUNTER_START:
                        case ($urandom_range(0, 2))
                            0: value = ALL1 - $urandom_range(0, 40);
                            1: value[31:0] = 32'hFFFF_FFFF - $urandom_range(0, 40);
                            default: ;
                        endcase
                    CFG_DOUBLE_ROUNDS:
                        value[3:0] = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                                 : 4'($urandom_range(1, 10));
                    CFG_UNUSED: ;
                    default:
                        case ($urandom_range(0, 7))
                            0: value = '0;
                            1: value = ALL1;
                            default: ;
                        endcase
                endcase
                write_reg(CFG_INDEX_W'(idx), value);
            end

            gaps_on = (phase % 4 != 1);
            // Fill the block against a stalled receiver
            if (phase == 2)
            begin
                gaps_on = 1'b0;
                hold_len = HOLD_CYCLES;
            end
            count = $urandom_range(40, 120);
            for (int n = 0; n < count; n++)
            begin
                if (phase % 5 == 3 && n == count / 2)
                    drain();
                send_block($urandom_range(0, 7) == 0, KNOWN_NONE, '0);
            end
        end

        drain();
        repeat (40) @(posedge clk);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[filelist.f]
sv/cha_pkg.sv
sv/cha_req_if.sv
sv/cha_rsp_if.sv
sv/cha_ctrl.sv
sv/cha_datapath.sv
sv/chacha_keystream_block.sv
sv/cha_checker.sv
tb/tb_chacha_keystream_block.sv
